### rtl/core/ccirc_pkg.sv
`default_nettype none
package ccirc_pkg;

  // Field widths fixed by the interface.
  localparam int IN_W  = 16;
  localparam int OUT_W = 32;
  localparam int ST_W  = 2;

  // Square-root datapath: 64-bit radicand, 32-bit root.
  localparam int SQ_W  = 64;
  localparam int RT_W  = 32;

  localparam logic signed [63:0] I32_MAX = 64'sd2147483647;
  localparam logic signed [63:0] I32_MIN = -64'sd2147483648;

  typedef enum logic [ST_W-1:0] {
    ST_VALID     = 2'd0,
    ST_COLLINEAR = 2'd1,
    ST_SAT       = 2'd2
  } ccirc_status_t;

  // Sideband carried alongside the square-root pipeline.
  typedef struct packed {
    logic [OUT_W-1:0] cx;
    logic [OUT_W-1:0] cy;
    logic             csat;
    logic             rsat;
    logic             dz;
  } ccirc_sq_sb_t;

endpackage
`default_nettype wire

### rtl/core/circumcircle_from_three_points_core.sv
`default_nettype none
// Channel | Direction | Handshake            | Payload
// in_     | input     | in_valid / in_stall  | ax, ay, bx, by_coord, cx, cy (16 b signed)
// out_    | output    | out_valid / out_stall| center_x, center_y (32 b signed),
//         |           |                      | radius (32 b unsigned), status (2 b)
//
// One transaction is accepted per clock cycle while in_stall is low. Data passes
// through the setup stages, the bit-per-stage divider, the centre stages, the
// bit-per-stage square root and the output register, in that order.
// Reset is synchronous and active low; it clears only the valid bits.
// A stalled result freezes the whole pipeline, so nothing is lost or repeated.
module circumcircle_from_three_points_core import ccirc_pkg::*; #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 8
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic signed [IN_W-1:0]  in_ax,
  input  wire logic signed [IN_W-1:0]  in_ay,
  input  wire logic signed [IN_W-1:0]  in_bx,
  input  wire logic signed [IN_W-1:0]  in_by_coord,
  input  wire logic signed [IN_W-1:0]  in_cx,
  input  wire logic signed [IN_W-1:0]  in_cy,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic signed [OUT_W-1:0]      out_center_x,
  output logic signed [OUT_W-1:0]      out_center_y,
  output logic [OUT_W-1:0]             out_radius,
  output logic [ST_W-1:0]              out_status
);

  // Dividend holds |numerator| scaled by 2^(FRAC_BITS+1) plus |D| for rounding;
  // the divisor is 2*|D|.
  localparam int CB  = COORD_BITS;
  localparam int NDW = 3*CB + FRAC_BITS + 5;
  localparam int DVW = 2*CB + 4;
  localparam int SBW = 2*CB + 3;

  logic out_valid_r;

  // The pipeline moves whenever the output register is empty or being drained.
  logic en;
  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  // Coordinates are the low COORD_BITS of each field.
  logic signed [CB-1:0] ax, ay, bx, by, cx, cy;
  assign ax = CB'($unsigned(in_ax));
  assign ay = CB'($unsigned(in_ay));
  assign bx = CB'($unsigned(in_bx));
  assign by = CB'($unsigned(in_by_coord));
  assign cx = CB'($unsigned(in_cx));
  assign cy = CB'($unsigned(in_cy));

  logic                 su_v, su_negx, su_negy, su_dz;
  logic [NDW-1:0]       su_nx, su_ny;
  logic [DVW-1:0]       su_dv;
  logic signed [CB-1:0] su_ax, su_ay;

  ccirc_setup #(.CB(CB), .FB(FRAC_BITS), .NDW(NDW), .DVW(DVW)) u_setup (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .v_i    (in_valid),
    .ax_i   (ax),
    .ay_i   (ay),
    .bx_i   (bx),
    .by_i   (by),
    .cx_i   (cx),
    .cy_i   (cy),
    .v_o    (su_v),
    .nx_o   (su_nx),
    .ny_o   (su_ny),
    .dv_o   (su_dv),
    .negx_o (su_negx),
    .negy_o (su_negy),
    .dz_o   (su_dz),
    .ax_o   (su_ax),
    .ay_o   (su_ay)
  );

  // The first point and the signs ride alongside the divider.
  logic [SBW-1:0] dv_sb_in, dv_sb_out;
  logic           dv_v;
  logic [NDW-1:0] dv_qx, dv_qy;

  assign dv_sb_in = {su_ax, su_ay, su_negx, su_negy, su_dz};

  ccirc_div #(.NDW(NDW), .DVW(DVW), .SBW(SBW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .v_i   (su_v),
    .nx_i  (su_nx),
    .ny_i  (su_ny),
    .dv_i  (su_dv),
    .sb_i  (dv_sb_in),
    .v_o   (dv_v),
    .qx_o  (dv_qx),
    .qy_o  (dv_qy),
    .sb_o  (dv_sb_out)
  );

  logic            po_v;
  logic [SQ_W-1:0] po_s;
  ccirc_sq_sb_t    po_sb;

  ccirc_post #(.CB(CB), .FB(FRAC_BITS), .NDW(NDW)) u_post (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .v_i    (dv_v),
    .qx_i   (dv_qx),
    .qy_i   (dv_qy),
    .ax_i   (dv_sb_out[SBW-1 -: CB]),
    .ay_i   (dv_sb_out[SBW-1-CB -: CB]),
    .negx_i (dv_sb_out[2]),
    .negy_i (dv_sb_out[1]),
    .dz_i   (dv_sb_out[0]),
    .v_o    (po_v),
    .s_o    (po_s),
    .sb_o   (po_sb)
  );

  logic            sq_v;
  logic [RT_W-1:0] sq_r;
  ccirc_sq_sb_t    sq_sb;

  ccirc_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .v_i   (po_v),
    .s_i   (po_s),
    .sb_i  (po_sb),
    .v_o   (sq_v),
    .r_o   (sq_r),
    .sb_o  (sq_sb)
  );

  // Output register. Collinear or coincident points give an all-zero circle.
  logic [OUT_W-1:0] cx_r, cy_r, rad_r;
  ccirc_status_t    st_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= sq_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (sq_sb.dz) begin
        cx_r  <= '0;
        cy_r  <= '0;
        rad_r <= '0;
        st_r  <= ST_COLLINEAR;
      end else begin
        cx_r  <= sq_sb.cx;
        cy_r  <= sq_sb.cy;
        rad_r <= sq_sb.rsat ? '1 : OUT_W'(sq_r);
        st_r  <= (sq_sb.csat || sq_sb.rsat) ? ST_SAT : ST_VALID;
      end
    end
  end

  assign out_valid    = out_valid_r;
  assign out_center_x = cx_r;
  assign out_center_y = cy_r;
  assign out_radius   = rad_r;
  assign out_status   = st_r;

endmodule
`default_nettype wire

### rtl/core/ccirc_setup.sv
`default_nettype none
module ccirc_setup import ccirc_pkg::*; #(
  parameter int CB  = 16,
  parameter int FB  = 8,
  parameter int NDW = 3*16+8+5,
  parameter int DVW = 2*16+4
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  en,
  input  wire logic                  v_i,
  input  wire logic signed [CB-1:0]  ax_i,
  input  wire logic signed [CB-1:0]  ay_i,
  input  wire logic signed [CB-1:0]  bx_i,
  input  wire logic signed [CB-1:0]  by_i,
  input  wire logic signed [CB-1:0]  cx_i,
  input  wire logic signed [CB-1:0]  cy_i,
  output logic                       v_o,
  output logic [NDW-1:0]             nx_o,
  output logic [NDW-1:0]             ny_o,
  output logic [DVW-1:0]             dv_o,
  output logic                       negx_o,
  output logic                       negy_o,
  output logic                       dz_o,
  output logic signed [CB-1:0]       ax_o,
  output logic signed [CB-1:0]       ay_o
);

  localparam int DW  = CB + 1;
  localparam int PW  = 2*DW;
  localparam int DDW = 2*CB + 4;
  localparam int SW  = 2*CB + 2;
  localparam int H   = CB + 1;
  localparam int MPW = DW + H + 1;
  localparam int NW  = 3*CB + 4;
  localparam int NS  = 6;

  logic              v_r  [NS];
  logic signed [CB-1:0] ax_r [NS];
  logic signed [CB-1:0] ay_r [NS];

  // Stage 1: offsets relative to the first point.
  logic signed [DW-1:0] bxr_r, byr_r, cxr_r, cyr_r;
  // Stage 2: cross products and squares.
  logic signed [PW-1:0] p1_r, p2_r, sbx_r, sby_r, scx_r, scy_r;
  logic signed [DW-1:0] bxr2_r, byr2_r, cxr2_r, cyr2_r;
  // Stage 3: determinant and squared lengths.
  logic signed [DDW-1:0] d3_r;
  logic [SW-1:0]         bb_r, cc_r;
  logic signed [DW-1:0]  bxr3_r, byr3_r, cxr3_r, cyr3_r;
  // Stage 4: split partial products.
  logic signed [MPW-1:0] xal_r, xah_r, xbl_r, xbh_r, yal_r, yah_r, ybl_r, ybh_r;
  logic signed [DDW-1:0] d4_r;
  // Stage 5: numerators.
  logic signed [NW-1:0]  nx_r, ny_r;
  logic signed [DDW-1:0] d5_r;
  // Stage 6: divider operands.
  logic [NDW-1:0] num_x_r, num_y_r;
  logic [DVW-1:0] dvs_r;
  logic           negx_r, negy_r, dz_r;

  logic signed [PW-1:0]  m1, m2, q1, q2, q3, q4;
  logic signed [MPW-1:0] xal_nxt, xah_nxt, xbl_nxt, xbh_nxt;
  logic signed [MPW-1:0] yal_nxt, yah_nxt, ybl_nxt, ybh_nxt;
  logic [NW-1:0]         mx, my;
  logic [DDW-1:0]        md;

  assign m1 = bxr_r * cyr_r;
  assign m2 = byr_r * cxr_r;
  assign q1 = bxr_r * bxr_r;
  assign q2 = byr_r * byr_r;
  assign q3 = cxr_r * cxr_r;
  assign q4 = cyr_r * cyr_r;

  assign xal_nxt = cyr3_r * $signed({1'b0, bb_r[H-1:0]});
  assign xah_nxt = cyr3_r * $signed({1'b0, bb_r[SW-1:H]});
  assign xbl_nxt = byr3_r * $signed({1'b0, cc_r[H-1:0]});
  assign xbh_nxt = byr3_r * $signed({1'b0, cc_r[SW-1:H]});
  assign yal_nxt = bxr3_r * $signed({1'b0, cc_r[H-1:0]});
  assign yah_nxt = bxr3_r * $signed({1'b0, cc_r[SW-1:H]});
  assign ybl_nxt = cxr3_r * $signed({1'b0, bb_r[H-1:0]});
  assign ybh_nxt = cxr3_r * $signed({1'b0, bb_r[SW-1:H]});

  assign mx = nx_r[NW-1] ? NW'(-nx_r) : NW'(nx_r);
  assign my = ny_r[NW-1] ? NW'(-ny_r) : NW'(ny_r);
  assign md = d5_r[DDW-1] ? DDW'(-d5_r) : DDW'(d5_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NS; i++) begin
        v_r[i] <= 1'b0;
      end
    end else if (en) begin
      v_r[0] <= v_i;
      for (int i = 1; i < NS; i++) begin
        v_r[i] <= v_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax_r[0] <= ax_i;
      ay_r[0] <= ay_i;
      for (int i = 1; i < NS; i++) begin
        ax_r[i] <= ax_r[i-1];
        ay_r[i] <= ay_r[i-1];
      end

      bxr_r <= DW'(bx_i) - DW'(ax_i);
      byr_r <= DW'(by_i) - DW'(ay_i);
      cxr_r <= DW'(cx_i) - DW'(ax_i);
      cyr_r <= DW'(cy_i) - DW'(ay_i);

      p1_r   <= m1;
      p2_r   <= m2;
      sbx_r  <= q1;
      sby_r  <= q2;
      scx_r  <= q3;
      scy_r  <= q4;
      bxr2_r <= bxr_r;
      byr2_r <= byr_r;
      cxr2_r <= cxr_r;
      cyr2_r <= cyr_r;

      d3_r   <= (DDW'(p1_r) - DDW'(p2_r)) <<< 1;
      bb_r   <= SW'($unsigned(sbx_r + sby_r));
      cc_r   <= SW'($unsigned(scx_r + scy_r));
      bxr3_r <= bxr2_r;
      byr3_r <= byr2_r;
      cxr3_r <= cxr2_r;
      cyr3_r <= cyr2_r;

      xal_r <= xal_nxt;
      xah_r <= xah_nxt;
      xbl_r <= xbl_nxt;
      xbh_r <= xbh_nxt;
      yal_r <= yal_nxt;
      yah_r <= yah_nxt;
      ybl_r <= ybl_nxt;
      ybh_r <= ybh_nxt;
      d4_r  <= d3_r;

      nx_r <= (NW'(xah_r) <<< H) + NW'(xal_r) - (NW'(xbh_r) <<< H) - NW'(xbl_r);
      ny_r <= (NW'(yah_r) <<< H) + NW'(yal_r) - (NW'(ybh_r) <<< H) - NW'(ybl_r);
      d5_r <= d4_r;

      num_x_r <= (NDW'(mx) << (FB + 1)) + NDW'(md);
      num_y_r <= (NDW'(my) << (FB + 1)) + NDW'(md);
      dvs_r   <= DVW'(md) << 1;
      negx_r  <= nx_r[NW-1] ^ d5_r[DDW-1];
      negy_r  <= ny_r[NW-1] ^ d5_r[DDW-1];
      dz_r    <= (d5_r == '0);
    end
  end

  assign v_o    = v_r[NS-1];
  assign nx_o   = num_x_r;
  assign ny_o   = num_y_r;
  assign dv_o   = dvs_r;
  assign negx_o = negx_r;
  assign negy_o = negy_r;
  assign dz_o   = dz_r;
  assign ax_o   = ax_r[NS-1];
  assign ay_o   = ay_r[NS-1];

endmodule
`default_nettype wire

### rtl/core/ccirc_div.sv
`default_nettype none
module ccirc_div import ccirc_pkg::*; #(
  parameter int NDW = 61,
  parameter int DVW = 36,
  parameter int SBW = 35
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           en,
  input  wire logic           v_i,
  input  wire logic [NDW-1:0] nx_i,
  input  wire logic [NDW-1:0] ny_i,
  input  wire logic [DVW-1:0] dv_i,
  input  wire logic [SBW-1:0] sb_i,
  output logic                v_o,
  output logic [NDW-1:0]      qx_o,
  output logic [NDW-1:0]      qy_o,
  output logic [SBW-1:0]      sb_o
);

  // One quotient bit per stage for both numerators, shared divisor.
  logic           v_r  [1:NDW];
  logic [DVW-1:0] rx_r [1:NDW];
  logic [DVW-1:0] ry_r [1:NDW];
  logic [NDW-1:0] qx_r [1:NDW];
  logic [NDW-1:0] qy_r [1:NDW];
  logic [DVW-1:0] dv_r [1:NDW];
  logic [SBW-1:0] sb_r [1:NDW];

  for (genvar k = 0; k < NDW; k++) begin : g_stage
    logic           cv;
    logic [DVW-1:0] crx, cry, cdv;
    logic [NDW-1:0] cqx, cqy;
    logic [SBW-1:0] csb;
    logic [DVW:0]   shx, shy, tx, ty;
    logic           gex, gey;

    if (k == 0) begin : g_first
      assign cv  = v_i;
      assign crx = '0;
      assign cry = '0;
      assign cqx = nx_i;
      assign cqy = ny_i;
      assign cdv = dv_i;
      assign csb = sb_i;
    end else begin : g_next
      assign cv  = v_r[k];
      assign crx = rx_r[k];
      assign cry = ry_r[k];
      assign cqx = qx_r[k];
      assign cqy = qy_r[k];
      assign cdv = dv_r[k];
      assign csb = sb_r[k];
    end

    assign shx = {crx, cqx[NDW-1]};
    assign shy = {cry, cqy[NDW-1]};
    assign gex = (shx >= {1'b0, cdv});
    assign gey = (shy >= {1'b0, cdv});
    assign tx  = shx - {1'b0, cdv};
    assign ty  = shy - {1'b0, cdv};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (en) begin
        v_r[k+1] <= cv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rx_r[k+1] <= gex ? tx[DVW-1:0] : shx[DVW-1:0];
        ry_r[k+1] <= gey ? ty[DVW-1:0] : shy[DVW-1:0];
        qx_r[k+1] <= {cqx[NDW-2:0], gex};
        qy_r[k+1] <= {cqy[NDW-2:0], gey};
        dv_r[k+1] <= cdv;
        sb_r[k+1] <= csb;
      end
    end
  end

  assign v_o  = v_r[NDW];
  assign qx_o = qx_r[NDW];
  assign qy_o = qy_r[NDW];
  assign sb_o = sb_r[NDW];

endmodule
`default_nettype wire

### rtl/core/ccirc_post.sv
`default_nettype none
module ccirc_post import ccirc_pkg::*; #(
  parameter int CB  = 16,
  parameter int FB  = 8,
  parameter int NDW = 61
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 en,
  input  wire logic                 v_i,
  input  wire logic [NDW-1:0]       qx_i,
  input  wire logic [NDW-1:0]       qy_i,
  input  wire logic signed [CB-1:0] ax_i,
  input  wire logic signed [CB-1:0] ay_i,
  input  wire logic                 negx_i,
  input  wire logic                 negy_i,
  input  wire logic                 dz_i,
  output logic                      v_o,
  output logic [SQ_W-1:0]           s_o,
  output ccirc_sq_sb_t              sb_o
);

  localparam int QEW = (NDW > 64) ? NDW : 64;

  logic [QEW-1:0]     qex, qey;
  logic signed [63:0] basex, basey, qvx, qvy;

  assign qex   = QEW'(qx_i);
  assign qey   = QEW'(qy_i);
  assign basex = 64'(ax_i) <<< FB;
  assign basey = 64'(ay_i) <<< FB;
  assign qvx   = $signed({2'b00, qex[61:0]});
  assign qvy   = $signed({2'b00, qey[61:0]});

  // First stage: offsets added to the base, squares of the offsets.
  logic               v1_r, v2_r;
  logic signed [63:0] vx_r, vy_r;
  logic [SQ_W-1:0]    sx_r, sy_r;
  logic               bigx_r, bigy_r, rbig_r, negx_r, negy_r, dz1_r;

  // Second stage: clamped centre and radicand.
  logic [SQ_W-1:0]    s_r;
  ccirc_sq_sb_t       sb_r;

  logic [SQ_W:0]      ssum;
  logic [OUT_W-1:0]   cx_nxt, cy_nxt;
  logic               csx, csy;

  assign ssum = {1'b0, sx_r} + {1'b0, sy_r};

  always_comb begin
    csx = 1'b1;
    csy = 1'b1;
    priority if (bigx_r) begin
      cx_nxt = negx_r ? I32_MIN[OUT_W-1:0] : I32_MAX[OUT_W-1:0];
    end else if (vx_r > I32_MAX) begin
      cx_nxt = I32_MAX[OUT_W-1:0];
    end else if (vx_r < I32_MIN) begin
      cx_nxt = I32_MIN[OUT_W-1:0];
    end else begin
      cx_nxt = vx_r[OUT_W-1:0];
      csx    = 1'b0;
    end
    priority if (bigy_r) begin
      cy_nxt = negy_r ? I32_MIN[OUT_W-1:0] : I32_MAX[OUT_W-1:0];
    end else if (vy_r > I32_MAX) begin
      cy_nxt = I32_MAX[OUT_W-1:0];
    end else if (vy_r < I32_MIN) begin
      cy_nxt = I32_MIN[OUT_W-1:0];
    end else begin
      cy_nxt = vy_r[OUT_W-1:0];
      csy    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= v_i;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vx_r   <= negx_i ? basex - qvx : basex + qvx;
      vy_r   <= negy_i ? basey - qvy : basey + qvy;
      sx_r   <= SQ_W'(qex[RT_W-1:0]) * SQ_W'(qex[RT_W-1:0]);
      sy_r   <= SQ_W'(qey[RT_W-1:0]) * SQ_W'(qey[RT_W-1:0]);
      bigx_r <= |(qex >> 62);
      bigy_r <= |(qey >> 62);
      rbig_r <= (|(qex >> RT_W)) | (|(qey >> RT_W));
      negx_r <= negx_i;
      negy_r <= negy_i;
      dz1_r  <= dz_i;

      s_r     <= ssum[SQ_W-1:0];
      sb_r.cx   <= cx_nxt;
      sb_r.cy   <= cy_nxt;
      sb_r.csat <= csx | csy;
      sb_r.rsat <= rbig_r | ssum[SQ_W];
      sb_r.dz   <= dz1_r;
    end
  end

  assign v_o  = v2_r;
  assign s_o  = s_r;
  assign sb_o = sb_r;

endmodule
`default_nettype wire

### rtl/core/ccirc_sqrt.sv
`default_nettype none
module ccirc_sqrt import ccirc_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            en,
  input  wire logic            v_i,
  input  wire logic [SQ_W-1:0] s_i,
  input  wire ccirc_sq_sb_t    sb_i,
  output logic                 v_o,
  output logic [RT_W-1:0]      r_o,
  output ccirc_sq_sb_t         sb_o
);

  // Digit-by-digit integer root, one result bit per stage.
  logic            v_r   [1:RT_W];
  logic [SQ_W-1:0] n_r   [1:RT_W];
  logic [SQ_W-1:0] res_r [1:RT_W];
  ccirc_sq_sb_t    sb_r  [1:RT_W];

  for (genvar k = 0; k < RT_W; k++) begin : g_stage
    localparam logic [SQ_W-1:0] BITV = SQ_W'(1) << (SQ_W - 2 - 2*k);
    logic            cv;
    logic [SQ_W-1:0] cn, cres, t;
    ccirc_sq_sb_t    csb;
    logic            ge;

    if (k == 0) begin : g_first
      assign cv   = v_i;
      assign cn   = s_i;
      assign cres = '0;
      assign csb  = sb_i;
    end else begin : g_next
      assign cv   = v_r[k];
      assign cn   = n_r[k];
      assign cres = res_r[k];
      assign csb  = sb_r[k];
    end

    assign t  = cres + BITV;
    assign ge = (cn >= t);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (en) begin
        v_r[k+1] <= cv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        n_r[k+1]   <= ge ? cn - t : cn;
        res_r[k+1] <= ge ? (cres >> 1) + BITV : cres >> 1;
        sb_r[k+1]  <= csb;
      end
    end
  end

  assign v_o  = v_r[RT_W];
  assign r_o  = res_r[RT_W][RT_W-1:0];
  assign sb_o = sb_r[RT_W];

endmodule
`default_nettype wire
